/* src/fpwc_pkg.sv */
// ----------------------------------------------------------------------------
// fpwc_pkg
// Shared types and constants for the frequent-pattern word compressor.
// ----------------------------------------------------------------------------
package fpwc_pkg;

	localparam int unsigned WordW   = 64;
	localparam int unsigned CodeW   = 3;
	localparam int unsigned PieceW  = WordW + CodeW;
	localparam int unsigned LenW    = 7;
	localparam int unsigned AccW    = 2 * WordW + 2;
	localparam int unsigned CntW    = 8;

	localparam logic [CodeW-1:0] CodeZero   = 3'd0;
	localparam logic [CodeW-1:0] CodeSext8  = 3'd1;
	localparam logic [CodeW-1:0] CodeSext16 = 3'd2;
	localparam logic [CodeW-1:0] CodeSext32 = 3'd3;
	localparam logic [CodeW-1:0] CodeLowZ   = 3'd4;
	localparam logic [CodeW-1:0] CodeHalves = 3'd5;
	localparam logic [CodeW-1:0] CodeRepeat = 3'd6;
	localparam logic [CodeW-1:0] CodeRaw    = 3'd7;

	typedef struct packed {
		logic [PieceW-1:0] bits;
		logic [LenW-1:0]   len;
	} piece_t;

endpackage

/* src/fpwc_classify.sv */
// ----------------------------------------------------------------------------
// fpwc_classify
// Matches one word against the patterns in priority order and forms its
// piece: payload with the 3-bit code directly above it.
// ----------------------------------------------------------------------------
module fpwc_classify
	import fpwc_pkg::*;
(
	input  logic [WordW-1:0] word,
	output piece_t           piece
);

	logic        is_zero, fit8, fit16, fit32, low_zero, halves, repeat16;
	logic [15:0] r;

	assign r        = word[15:0];
	assign is_zero  = (word == '0);
	assign fit8     = (&word[63:7])  | ~(|word[63:7]);
	assign fit16    = (&word[63:15]) | ~(|word[63:15]);
	assign fit32    = (&word[63:31]) | ~(|word[63:31]);
	assign low_zero = (word[31:0] == '0);
	assign halves   = ((&word[63:47]) | ~(|word[63:47])) &
	                  ((&word[31:15]) | ~(|word[31:15]));
	assign repeat16 = (word == {r, r, r, r});

	always_comb begin
		piece = '0;
		if (is_zero) begin
			piece.bits = PieceW'(CodeZero);
			piece.len  = LenW'(CodeW);
		end else if (fit8) begin
			piece.bits = PieceW'({CodeSext8, word[7:0]});
			piece.len  = LenW'(CodeW + 8);
		end else if (fit16) begin
			piece.bits = PieceW'({CodeSext16, word[15:0]});
			piece.len  = LenW'(CodeW + 16);
		end else if (fit32) begin
			piece.bits = PieceW'({CodeSext32, word[31:0]});
			piece.len  = LenW'(CodeW + 32);
		end else if (low_zero) begin
			piece.bits = PieceW'({CodeLowZ, word[63:32]});
			piece.len  = LenW'(CodeW + 32);
		end else if (halves) begin
			piece.bits = PieceW'({CodeHalves, word[47:32], word[15:0]});
			piece.len  = LenW'(CodeW + 32);
		end else if (repeat16) begin
			piece.bits = PieceW'({CodeRepeat, r});
			piece.len  = LenW'(CodeW + 16);
		end else begin
			piece.bits = {CodeRaw, word};
			piece.len  = LenW'(PieceW);
		end
	end

endmodule

/* src/frequent_pattern_word_compressor_unit.sv */
// ----------------------------------------------------------------------------
// frequent_pattern_word_compressor_unit
// Frequent-pattern compressor for 64-bit words with a packed 64-bit output.
// ----------------------------------------------------------------------------
// Input channel s_*: one 64-bit word per transaction, s_tlast marks the
// final word of a block. Output channel m_*: 64 bits of the packed code
// stream per transaction (earliest bit in bit 0), the count of meaningful
// bits beside it, and m_tlast on the final word of a block.
// Each word becomes a 3..67-bit piece that is appended to an accumulator
// of up to 130 bits; full words leave it one per cycle while m_tready is
// high, and a partial word is flushed zero-padded after the last input of
// a block. A word passes through the input register, the accumulator and
// the output register before it shows on m_*. Throughput: one input per
// cycle while s_tready is high; the accumulator drains one 64-bit word per
// cycle, so a run of uncompressed words (67 bits each) adds bits faster
// than they drain and in time drops s_tready. After the last word of a
// block the next word waits for the block's final output word to leave.
// Reset clears the input stage, accumulator and output register; no block
// is in progress afterwards. When m_tready is low the output register
// holds, the accumulator fills, and s_tready drops once it holds 64 bits
// that have not yet been given out.
// ----------------------------------------------------------------------------
module frequent_pattern_word_compressor_unit
	import fpwc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [63:0] word
	input  logic        s_tlast,   // last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // [63:0] packed_word, [70:64] valid_bits
	output logic        m_tlast    // end_of_block
);

	logic [WordW-1:0] word_s1;
	logic             last_s1, valid_s1;
	piece_t           piece;

	logic [AccW-1:0]  acc_q, base, acc_d;
	logic [CntW-1:0]  acc_cnt_q, base_cnt;
	logic             acc_last_q, base_last;

	logic [WordW-1:0] out_word_q;
	logic [LenW-1:0]  out_bits_q;
	logic             out_eob_q, out_valid_q;

	logic emit_full, emit_flush, emit_fire, emit_eob, out_free;
	logic merge_ok, merge_fire;

	fpwc_classify u_classify (
		.word  (word_s1),
		.piece (piece)
	);

	assign out_free   = !out_valid_q || m_tready;
	assign emit_full  = (acc_cnt_q >= CntW'(WordW));
	assign emit_flush = !emit_full && acc_last_q && (acc_cnt_q != '0);
	assign emit_fire  = (emit_full || emit_flush) && out_free;
	assign emit_eob   = emit_flush || (acc_last_q && acc_cnt_q == CntW'(WordW));

	always_comb begin
		base      = acc_q;
		base_cnt  = acc_cnt_q;
		base_last = acc_last_q;
		if (emit_fire) begin
			if (emit_full) begin
				base     = acc_q >> WordW;
				base_cnt = acc_cnt_q - CntW'(WordW);
			end else begin
				base     = '0;
				base_cnt = '0;
			end
			if (emit_eob) begin
				base_last = 1'b0;
			end
		end
	end

	assign merge_ok   = (base_cnt < CntW'(WordW)) && !base_last;
	assign merge_fire = valid_s1 && merge_ok;
	assign acc_d      = base | (AccW'(piece.bits) << base_cnt[5:0]);
	assign s_tready   = !valid_s1 || merge_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			word_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q      <= '0;
			acc_cnt_q  <= '0;
			acc_last_q <= 1'b0;
		end else if (merge_fire) begin
			acc_q      <= acc_d;
			acc_cnt_q  <= base_cnt + CntW'(piece.len);
			acc_last_q <= last_s1;
		end else begin
			acc_q      <= base;
			acc_cnt_q  <= base_cnt;
			acc_last_q <= base_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= emit_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			out_word_q <= acc_q[WordW-1:0];
			out_bits_q <= emit_full ? LenW'(WordW) : acc_cnt_q[LenW-1:0];
			out_eob_q  <= emit_eob;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_bits_q, out_word_q};
	assign m_tlast  = out_eob_q;

endmodule

/* src/fpwc_checker.sv */
// ----------------------------------------------------------------------------
// fpwc_checker
// Port-level checks for the compressor output channel, bound to the top.
// ----------------------------------------------------------------------------
module fpwc_checker
	import fpwc_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [71:0] m_tdata,
	input logic        m_tlast
);

	// bit count of a transaction lies in 1..64
	a_bits_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[70:64] != 7'd0) && (m_tdata[70:64] <= 7'd64))
		else $error("valid_bits out of range");

	// only the final word of a block may be partial
	a_partial_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[70:64] != 7'd64) |-> m_tlast)
		else $error("partial word without end of block");

	// a stalled transaction holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output changed while stalled");

endmodule

bind frequent_pattern_word_compressor_unit fpwc_checker u_fpwc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
